@@ rtl/core/res_pkg.sv @@
// res_pkg: shared widths, record layout and default capacity for the
// record exchange sort block. No dependencies.
package res_pkg;

    localparam int RES_MAX_RECORDS = 64;
    localparam int KEY_W           = 16;
    localparam int PAY_W           = 64;
    localparam int REC_W           = KEY_W + PAY_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_record;

endpackage

@@ rtl/core/res_ram.sv @@
// res_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
module res_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/record_exchange_sort_descending.sv @@
// record_exchange_sort_descending: collects records, exchange-sorts them by
// key into descending order and streams them out.
// Depends on res_pkg and res_ram.
//
// Usage:
//   A request (key, payload, final flag) is taken on a clock edge where start
//   is high and busy is low. Records are written in arrival order into one
//   record RAM; once MAX_RECORDS are held, further records are dropped.
//   After a non-final request busy stays low.
//   A request with the final flag set starts the sort: busy rises and stays
//   high until the last result has been issued. The sort uses the single
//   compare unit and the one read and one write port of the record RAM:
//   one key compare per cycle. The n results then follow back to back,
//   each marked by o_valid for one cycle, the last also by o_end_of_run.
//   After the sort ends, each result is read from the RAM in state S_OUT
//   and appears with o_valid from the registered read data.
//   The receiver cannot stall: each result must be taken in its cycle.
//   Reset (synchronous, active low) empties the record set and returns the
//   block to idle; RAM contents are not cleared.
module record_exchange_sort_descending
    import res_pkg::*;
#(
    parameter int MAX_RECORDS = RES_MAX_RECORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [KEY_W-1:0] i_sort_key,
    input  logic [PAY_W-1:0] i_payload,
    input  logic             i_final_record,
    output logic             o_valid,
    output logic [KEY_W-1:0] o_sorted_key,
    output logic [PAY_W-1:0] o_sorted_payload,
    output logic             o_end_of_run
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOADA,
        S_CMP,
        S_WRA,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_lst;
    logic [AW-1:0]   r_a;
    logic [AW-1:0]   r_b;
    logic [AW-1:0]   r_o;
    t_record         r_cur;
    logic            r_vld;
    logic            r_end;

    logic [CW-1:0]   n_cnt;
    logic            accept;
    logic            space;
    logic            swap;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_record         ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    t_record         rd_rec;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign space  = (r_cnt != FULL);
    assign n_cnt  = space ? CW'(r_cnt + 1'b1) : r_cnt;
    assign rd_rec = t_record'(ram_rdata);
    assign swap   = (r_cur.key < rd_rec.key);

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = '{key: i_sort_key, payload: i_payload};
        ram_re    = 1'b0;
        ram_raddr = r_a;
        case (r_state)
            S_IDLE: begin
                ram_we = accept && space;
            end
            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_a;
            end
            S_LOADA: begin
                ram_re    = 1'b1;
                ram_raddr = r_b;
            end
            S_CMP: begin
                ram_re    = (r_b != r_lst);
                ram_raddr = AW'(r_b + 1'b1);
                ram_we    = swap;
                ram_waddr = r_b;
                ram_wdata = r_cur;
            end
            S_WRA: begin
                ram_we    = 1'b1;
                ram_waddr = r_a;
                ram_wdata = r_cur;
                ram_re    = (r_a != r_lst);
                ram_raddr = AW'(r_a + 1'b1);
            end
            S_OUT: begin
                ram_re    = 1'b1;
                ram_raddr = r_o;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vld   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_vld <= 1'b0;
            r_end <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_final_record) begin
                            r_cnt <= '0;
                            r_lst <= AW'(n_cnt - 1'b1);
                            r_a   <= '0;
                            r_o   <= '0;
                            if (n_cnt >= CW'(2)) begin
                                r_state <= S_FETCH;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_FETCH: begin
                    r_b     <= AW'(r_a + 1'b1);
                    r_state <= S_LOADA;
                end
                S_LOADA: begin
                    r_cur   <= rd_rec;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (swap) begin
                        r_cur <= rd_rec;
                    end
                    if (r_b == r_lst) begin
                        r_state <= S_WRA;
                    end else begin
                        r_b <= AW'(r_b + 1'b1);
                    end
                end
                S_WRA: begin
                    if (AW'(r_a + 1'b1) == r_lst) begin
                        r_o     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_a     <= AW'(r_a + 1'b1);
                        r_b     <= AW'(r_a + AW'(2));
                        r_state <= S_LOADA;
                    end
                end
                S_OUT: begin
                    r_vld <= 1'b1;
                    r_end <= (r_o == r_lst);
                    if (r_o == r_lst) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_o <= AW'(r_o + 1'b1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    res_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid          = r_vld;
    assign o_end_of_run     = r_end;
    assign o_sorted_key     = rd_rec.key;
    assign o_sorted_payload = rd_rec.payload;

    // output burst is contiguous and keys never rise within it
    a_desc_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_run |=> o_valid && (o_sorted_key <= $past(o_sorted_key)))
        else $error("sorted output not contiguous or not descending");

    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_run |-> o_valid)
        else $error("end of run without strobe");

    a_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_run |=> !o_valid)
        else $error("result after end of run");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_final_record |=> busy)
        else $error("final request did not start the sort");

endmodule

@@ tb/record_exchange_sort_descending_tb.sv @@
// record_exchange_sort_descending_tb: self-checking bench for the record exchange
// sort block, with a built-in descending-sort predictor, directed and random record sets.
// Depends on res_pkg and the record_exchange_sort_descending RTL.
module record_exchange_sort_descending_tb;
    import res_pkg::*;

    localparam int CAPACITY = RES_MAX_RECORDS;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             last;
    } t_sorted_entry;

    logic             i_clk;
    logic             i_rst_n          = 1'b0;
    logic             start            = 1'b0;
    logic             busy;
    logic [KEY_W-1:0] i_sort_key       = '0;
    logic [PAY_W-1:0] i_payload        = '0;
    logic             i_final_record   = 1'b0;
    logic             o_valid;
    logic [KEY_W-1:0] o_sorted_key;
    logic [PAY_W-1:0] o_sorted_payload;
    logic             o_end_of_run;

    logic [KEY_W-1:0] held_keys [CAPACITY];
    logic [PAY_W-1:0] held_payloads [CAPACITY];
    int               held_count;
    t_sorted_entry    expected_sorted [$];
    int               mismatches;
    int               sender_idle_pct;
    int               requests_sent;

    record_exchange_sort_descending dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sort_key       (i_sort_key),
        .i_payload        (i_payload),
        .i_final_record   (i_final_record),
        .o_valid          (o_valid),
        .o_sorted_key     (o_sorted_key),
        .o_sorted_payload (o_sorted_payload),
        .o_end_of_run     (o_end_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void store_and_sort(input logic [KEY_W-1:0] key,
                                           input logic [PAY_W-1:0] pay, input logic fin);
        t_sorted_entry    entry;
        logic [KEY_W-1:0] tk;
        logic [PAY_W-1:0] tp;
        if (held_count < CAPACITY) begin
            held_keys[held_count]     = key;
            held_payloads[held_count] = pay;
            held_count++;
        end
        if (!fin) return;
        for (int a = 0; a + 1 < held_count; a++) begin
            for (int b = a + 1; b < held_count; b++) begin
                if (held_keys[a] < held_keys[b]) begin
                    tk               = held_keys[a];
                    tp               = held_payloads[a];
                    held_keys[a]     = held_keys[b];
                    held_payloads[a] = held_payloads[b];
                    held_keys[b]     = tk;
                    held_payloads[b] = tp;
                end
            end
        end
        for (int k = 0; k < held_count; k++) begin
            entry.key     = held_keys[k];
            entry.payload = held_payloads[k];
            entry.last    = (k == held_count - 1);
            expected_sorted.push_back(entry);
        end
        held_count = 0;
    endfunction

    function automatic logic [PAY_W-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin
        t_sorted_entry want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_sorted.size() == 0) begin
                $error("unexpected result key=%h payload=%h end=%b",
                       o_sorted_key, o_sorted_payload, o_end_of_run);
                mismatches++;
            end else begin
                want = expected_sorted.pop_front();
                if (o_sorted_key !== want.key) begin
                    $error("sorted_key expected %h actual %h", want.key, o_sorted_key);
                    mismatches++;
                end
                if (o_sorted_payload !== want.payload) begin
                    $error("sorted_payload expected %h actual %h",
                           want.payload, o_sorted_payload);
                    mismatches++;
                end
                if (o_end_of_run !== want.last) begin
                    $error("end_of_run expected %b actual %b", want.last, o_end_of_run);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_record(input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay,
                               input logic fin);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sort_key     <= key;
        i_payload      <= pay;
        i_final_record <= fin;
        do @(posedge i_clk); while (busy !== 1'b0);
        store_and_sort(key, pay, fin);
        requests_sent++;
    endtask

    task automatic test_single_record();
        send_record('0, '0, 1'b1);
        send_record('1, '1, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_record(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_record(16'hFFFF, 64'h0000_0000_0000_0000, 1'b0);
        send_record(16'hAAAA, 64'h5555_5555_5555_5555, 1'b0);
        send_record(16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_record(16'h8000, 64'h8000_0000_0000_0001, 1'b0);
        send_record(16'h0001, 64'h0123_4567_89AB_CDEF, 1'b1);
    endtask

    task automatic test_tie_order();
        logic [KEY_W-1:0] tie_keys [6];
        tie_keys = '{16'd5, 16'd5, 16'd3, 16'd5, 16'd3, 16'd7};
        for (int i = 0; i < 6; i++) send_record(tie_keys[i], PAY_W'(i + 1), i == 5);
        // ascending input, then already descending
        for (int i = 0; i < 5; i++) send_record(KEY_W'(i + 1), rand_payload(), i == 4);
        for (int i = 0; i < 4; i++) send_record(KEY_W'(40 - i), rand_payload(), i == 3);
    endtask

    task automatic test_store_full();
        // final request lands exactly on the last free slot
        for (int i = 0; i < CAPACITY; i++)
            send_record(KEY_W'($urandom_range(15)), rand_payload(), i == CAPACITY - 1);
        // overflow records are dropped, a dropped final still triggers the sort
        for (int i = 0; i < CAPACITY + 1; i++)
            send_record(KEY_W'($urandom), rand_payload(), i == CAPACITY);
    endtask

    task automatic test_random_sets(input int idle_pct, input int request_goal);
        int               set_size;
        int               pick;
        bit               narrow_keys;
        logic [KEY_W-1:0] key;
        sender_idle_pct = idle_pct;
        requests_sent   = 0;
        while (requests_sent < request_goal) begin
            pick = $urandom_range(99);
            if (pick < 90) set_size = $urandom_range(1, 8);
            else set_size = $urandom_range(9, 16);
            narrow_keys = $urandom_range(2) == 0;
            for (int i = 0; i < set_size; i++) begin
                key = narrow_keys ? KEY_W'($urandom_range(3)) : KEY_W'($urandom);
                send_record(key, rand_payload(), i == set_size - 1);
            end
        end
    endtask

    initial begin
        mismatches      = 0;
        held_count      = 0;
        requests_sent   = 0;
        sender_idle_pct = 12;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_record();
        test_extreme_values();
        test_tie_order();
        test_store_full();
        test_random_sets(12, 4);
        test_random_sets(87, 4);
        test_random_sets(0, 4);

        start <= 1'b0;
        while (expected_sorted.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/res_pkg.sv
rtl/core/res_ram.sv
rtl/core/record_exchange_sort_descending.sv
tb/record_exchange_sort_descending_tb.sv
